/* rtl/core/alu_with_condition_codes_and_branch_macros.svh */
// Assertion macros for the ALU checker
`ifndef ALU_WITH_CONDITION_CODES_AND_BRANCH_MACROS_SVH
`define ALU_WITH_CONDITION_CODES_AND_BRANCH_MACROS_SVH

// implication checked on every clock edge outside reset
`define ACC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ACC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/acc_pkg.sv */
// ----------------------------------------------------------------------------
// acc_pkg
// Shared types and constants for the ALU with condition codes.
// ----------------------------------------------------------------------------
`default_nettype none
package acc_pkg;
    localparam int unsigned DataWidthDef = 32;
    localparam int unsigned FieldW       = 32;
    localparam int unsigned SegW         = 16;

    typedef enum logic [4:0] {
        OP_SUB = 5'd0,  OP_MUL = 5'd1,  OP_DIV = 5'd2,  OP_CMP = 5'd3,
        OP_AND = 5'd4,  OP_OR  = 5'd5,  OP_XOR = 5'd6,  OP_SWAP = 5'd7,
        OP_SHL = 5'd8,  OP_SHR = 5'd9,  OP_SAR = 5'd10, OP_LDL = 5'd11,
        OP_LDH = 5'd12, OP_NOT = 5'd13, OP_JMP = 5'd14, OP_JP  = 5'd15,
        OP_JN  = 5'd16, OP_JZ  = 5'd17, OP_JC  = 5'd18, OP_JV  = 5'd19,
        OP_JNP = 5'd20, OP_JNN = 5'd21, OP_JNZ = 5'd22
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_DIV0 = 2'd1, ST_BADOP = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE, S_EXEC, S_MUL, S_DIV, S_FIN, S_OUT
    } t_state;

    localparam int unsigned FlagN = 0;
    localparam int unsigned FlagZ = 1;
    localparam int unsigned FlagC = 2;
    localparam int unsigned FlagV = 3;

    typedef struct packed {
        logic load;      // capture operands
        logic exec;      // non-iterative ops
        logic mul;       // multiply step
        logic div_step;  // one quotient bit
        logic fin;       // sign fixup / result
        logic out_take;  // output word consumed
    } t_cmd;

    typedef struct packed {
        logic is_mul;
        logic is_div;
        logic div_last;
    } t_stat;
endpackage
`default_nettype wire

/* rtl/core/acc_ctrl.sv */
// ----------------------------------------------------------------------------
// acc_ctrl
// Sequencer: load, execute, multiply or iterate divide, present result.
// ----------------------------------------------------------------------------
`default_nettype none
module acc_ctrl
    import acc_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    input  wire t_stat  i_stat,
    output t_cmd        o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_EXEC;
            S_EXEC: begin
                if (i_stat.is_mul) n_state = S_MUL;
                else if (i_stat.is_div) n_state = S_DIV;
                else n_state = S_OUT;
            end
            S_MUL: n_state = S_FIN;
            S_DIV: if (i_stat.div_last) n_state = S_FIN;
            S_FIN: n_state = S_OUT;
            S_OUT: if (i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_EXEC: o_cmd.exec = 1'b1;
            S_MUL:  o_cmd.mul = 1'b1;
            S_DIV:  o_cmd.div_step = 1'b1;
            S_FIN:  o_cmd.fin = 1'b1;
            S_OUT: begin
                o_out_valid  = 1'b1;
                o_cmd.out_take = i_out_ready;
            end
            default: o_cmd = '0;
        endcase
    end
endmodule
`default_nettype wire

/* rtl/core/acc_dp.sv */
// ----------------------------------------------------------------------------
// acc_dp
// Datapath: operand registers, flags, multiplier, restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none
module acc_dp
    import acc_pkg::*;
#(
    parameter int unsigned DATA_WIDTH = DataWidthDef
)(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire t_cmd           i_cmd,
    output t_stat               o_stat,
    input  wire [4:0]           i_opcode,
    input  wire [FieldW-1:0]    i_a,
    input  wire [FieldW-1:0]    i_b,
    input  wire [SegW-1:0]      i_seg,
    output logic [FieldW-1:0]   o_dest,
    output logic                o_dest_wr,
    output logic [FieldW-1:0]   o_second,
    output logic                o_second_wr,
    output logic [FieldW-1:0]   o_rem,
    output logic                o_rem_wr,
    output logic                o_taken,
    output logic [FieldW-1:0]   o_target,
    output logic [3:0]          o_flags,
    output logic [1:0]          o_status
);
    localparam int unsigned DW  = DATA_WIDTH;
    localparam int unsigned CW  = $clog2(DW + 1);
    localparam logic [CW-1:0] LastCnt = CW'(DW - 1);

    logic [4:0]    r_op;
    logic [DW-1:0] r_a, r_b, r_ma, r_mb;
    logic          r_sa, r_sb;
    logic [3:0]    r_flags;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_q, r_r;
    logic [2*DW-1:0] r_prod;

    logic [FieldW-1:0] r_dest, r_second, r_rem, r_target;
    logic r_dest_wr, r_second_wr, r_rem_wr, r_taken;
    logic [1:0] r_status;

    function automatic logic [DW-1:0] trunc(input logic [FieldW-1:0] v);
        logic [FieldW+DW-1:0] e;
        e = {{DW{v[FieldW-1]}}, v};
        return e[DW-1:0];
    endfunction

    function automatic logic [FieldW-1:0] widen(input logic [DW-1:0] v);
        logic [FieldW+DW-1:0] e;
        e = {{FieldW{1'b0}}, v};
        return e[FieldW-1:0];
    endfunction

    function automatic logic [1:0] nz(input logic [DW-1:0] v);
        return {v == '0, v[DW-1]};
    endfunction

    logic [DW-1:0] a_in, b_in;
    assign a_in = trunc(i_a);
    assign b_in = trunc(i_b);

    logic [FieldW-1:0] a_wide;
    assign a_wide = widen(r_a);

    // non-iterative result
    logic [DW-1:0] x_res, sub_r;
    logic [3:0]    x_flags;
    logic          x_wr, x_sw, x_taken, x_cond;
    logic [1:0]    x_status;
    logic          big_cnt;
    logic [DW-1:0] sar_r;

    assign sub_r   = r_a - r_b;
    assign big_cnt = r_b >= DW;
    assign sar_r   = DW'($signed(r_a) >>> r_b);

    always_comb begin
        x_res = '0; x_wr = 1'b0; x_sw = 1'b0; x_taken = 1'b0; x_cond = 1'b0;
        x_status = ST_OK; x_flags = r_flags;
        case (t_opcode'(r_op))
            OP_SUB, OP_CMP: begin
                x_flags = {(r_a[DW-1] ^ r_b[DW-1]) & (r_a[DW-1] ^ sub_r[DW-1]),
                           r_a < r_b, nz(sub_r)};
                x_res = (r_op == OP_SUB) ? sub_r : '0;
                x_wr  = (r_op == OP_SUB);
            end
            OP_AND: begin x_res = r_a & r_b; x_wr = 1'b1; end
            OP_OR:  begin x_res = r_a | r_b; x_wr = 1'b1; end
            OP_XOR: begin x_res = r_a ^ r_b; x_wr = 1'b1; end
            OP_SWAP: begin x_res = r_b; x_wr = 1'b1; x_sw = 1'b1; end
            OP_SHL: begin x_res = big_cnt ? '0 : r_a << r_b; x_wr = 1'b1; end
            OP_SHR: begin x_res = big_cnt ? '0 : r_a >> r_b; x_wr = 1'b1; end
            OP_SAR: begin
                x_res = big_cnt ? {DW{r_a[DW-1]}} : sar_r; x_wr = 1'b1;
            end
            OP_LDL: begin
                x_res = trunc(widen(r_a) & 32'hFFFF0000 | widen(r_b) & 32'h0000FFFF);
                x_wr = 1'b1;
            end
            OP_LDH: begin
                x_res = trunc((widen(r_a) & 32'h0000FFFF) |
                              ((widen(r_b) & 32'h0000FFFF) << 16));
                x_wr = 1'b1;
            end
            OP_NOT: begin x_res = ~r_a; x_wr = 1'b1; end
            OP_JMP: x_cond = 1'b1;
            OP_JP:  x_cond = !r_flags[FlagN] && !r_flags[FlagZ];
            OP_JN:  x_cond = r_flags[FlagN];
            OP_JZ:  x_cond = r_flags[FlagZ];
            OP_JC:  x_cond = r_flags[FlagC];
            OP_JV:  x_cond = r_flags[FlagV];
            OP_JNP: x_cond = r_flags[FlagN] || r_flags[FlagZ];
            OP_JNN: x_cond = !r_flags[FlagN];
            OP_JNZ: x_cond = !r_flags[FlagZ];
            OP_MUL, OP_DIV: x_status = ST_OK;
            default: x_status = ST_BADOP;
        endcase
        case (t_opcode'(r_op))
            OP_AND, OP_OR, OP_XOR, OP_SHL, OP_SHR, OP_SAR, OP_NOT:
                x_flags = {2'b00, nz(x_res)};
            OP_SWAP: x_flags = {2'b00, nz(r_a)};
            default: x_taken = x_cond;
        endcase
    end

    logic is_jmp, is_mul, is_div;
    assign is_jmp = (r_op >= OP_JMP) && (r_op <= OP_JNZ);
    assign is_mul = (r_op == OP_MUL);
    assign is_div = (r_op == OP_DIV) && (r_b != '0);

    assign o_stat.is_mul   = is_mul;
    assign o_stat.is_div   = is_div;
    assign o_stat.div_last = (r_cnt == LastCnt);

    // divider step
    logic [DW:0]   d_trial;
    logic [DW-1:0] d_shift;
    assign d_shift = {r_r[DW-2:0], r_q[DW-1]};
    assign d_trial = {1'b0, d_shift} - {1'b0, r_mb};

    // multiply fixup
    logic [DW-1:0] m_lo, m_hi, m_res, m_lim;
    logic          m_neg, m_ovf;
    assign m_lo  = r_prod[DW-1:0];
    assign m_hi  = r_prod[2*DW-1:DW];
    assign m_neg = (r_sa ^ r_sb) && (m_lo != '0);
    assign m_res = m_neg ? -m_lo : m_lo;
    assign m_lim = {~r_sa ^ r_sb ? 1'b0 : 1'b1, {(DW-1){~(r_sa ^ r_sb)}}};
    assign m_ovf = (m_hi != '0) || (m_lo > m_lim);

    logic [DW-1:0] dv_q, dv_r;
    assign dv_q = (r_sa ^ r_sb) ? -r_q : r_q;
    assign dv_r = r_sa ? -r_r : r_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else if (i_cmd.exec && !is_mul && !is_div) begin
            r_flags <= x_flags;
        end else if (i_cmd.fin) begin
            r_flags <= is_mul ? {m_ovf, m_ovf, nz(m_res)} : {2'b00, nz(dv_q)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_opcode;
            r_a  <= a_in;
            r_b  <= b_in;
            r_sa <= a_in[DW-1];
            r_sb <= b_in[DW-1];
            r_ma <= a_in[DW-1] ? -a_in : a_in;
            r_mb <= b_in[DW-1] ? -b_in : b_in;
        end
        if (i_cmd.exec) begin
            r_cnt  <= '0;
            r_q    <= r_ma;
            r_r    <= '0;
            r_dest <= widen(x_res);
            r_dest_wr   <= x_wr;
            r_second    <= x_sw ? widen(r_a) : '0;
            r_second_wr <= x_sw;
            r_rem       <= '0;
            r_rem_wr    <= 1'b0;
            r_taken     <= x_taken;
            r_target    <= is_jmp ? {i_seg, a_wide[15:0]} : '0;
            r_status    <= (r_op == OP_DIV && r_b == '0) ? ST_DIV0 : x_status;
        end
        if (i_cmd.mul) r_prod <= r_ma * r_mb;
        if (i_cmd.div_step) begin
            r_cnt <= r_cnt + 1'b1;
            if (!d_trial[DW]) begin
                r_r <= d_trial[DW-1:0];
                r_q <= {r_q[DW-2:0], 1'b1};
            end else begin
                r_r <= d_shift;
                r_q <= {r_q[DW-2:0], 1'b0};
            end
        end
        if (i_cmd.fin) begin
            r_dest_wr <= 1'b1;
            if (is_mul) begin
                r_dest <= widen(m_res);
            end else begin
                r_dest   <= widen(dv_q);
                r_rem    <= widen(dv_r);
                r_rem_wr <= 1'b1;
            end
        end
    end

    assign o_dest      = r_dest;
    assign o_dest_wr   = r_dest_wr;
    assign o_second    = r_second;
    assign o_second_wr = r_second_wr;
    assign o_rem       = r_rem;
    assign o_rem_wr    = r_rem_wr;
    assign o_taken     = r_taken;
    assign o_target    = r_target;
    assign o_flags     = r_flags;
    assign o_status    = r_status;
endmodule
`default_nettype wire

/* rtl/core/alu_with_condition_codes_and_branch.sv */
// ----------------------------------------------------------------------------
// alu_with_condition_codes_and_branch
// ALU with NZCV flags, iterative divide and branch resolution.
// ----------------------------------------------------------------------------
// channel   dir  fields (low bit up)
// s_axis    in   tdata: opcode[4:0], operand_a[36:5], operand_b[68:37]
// m_axis    out  tdata: dest, dest_write, second, second_write, rem, rem_write,
//                taken, target, flags, status
// apb       in   reg 0 code_segment_high at 0x0
// Sequence: load, execute, multiply or divide steps and fixup for mul/div, then output handshake.
// Divide time is set by the one-bit-per-cycle restoring divider.
// One item at a time; input stalls until the result word is taken.
// Reset clears flags, segment register and the sequencer.
`default_nettype none
module alu_with_condition_codes_and_branch
    import acc_pkg::*;
#(
    parameter int unsigned DATA_WIDTH = DataWidthDef
)(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire  [71:0]  s_axis_tdata,   // opcode, operand_a, operand_b
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    output logic [143:0] m_axis_tdata,   // dest..status, see table above
    input  wire          psel,
    input  wire          penable,
    input  wire          pwrite,
    input  wire  [1:0]   paddr,
    input  wire  [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    logic [SegW-1:0] r_seg;
    t_cmd  cmd;
    t_stat stat;

    logic [FieldW-1:0] dest, second, rem, target;
    logic dw, sw, rw, tk;
    logic [3:0] fl;
    logic [1:0] st;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {16'h0, r_seg} : 32'h0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_seg <= '0;
        else if (psel && penable && pwrite && paddr == 2'd0) r_seg <= pwdata[15:0];
    end

    acc_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid (s_axis_tvalid), .o_in_ready (s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_stat(stat), .o_cmd(cmd)
    );

    acc_dp #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_stat(stat),
        .i_opcode(s_axis_tdata[4:0]), .i_a(s_axis_tdata[36:5]),
        .i_b(s_axis_tdata[68:37]), .i_seg(r_seg),
        .o_dest(dest), .o_dest_wr(dw), .o_second(second), .o_second_wr(sw),
        .o_rem(rem), .o_rem_wr(rw), .o_taken(tk), .o_target(target),
        .o_flags(fl), .o_status(st)
    );

    assign m_axis_tdata = {6'h0, st, fl, target, tk, rw, rem, sw, second, dw, dest};
endmodule
`default_nettype wire

/* rtl/core/acc_chk.sv */
// ----------------------------------------------------------------------------
// acc_chk
// Port-level checks for the ALU.
// ----------------------------------------------------------------------------
`default_nettype none
`include "alu_with_condition_codes_and_branch_macros.svh"
module acc_chk (
    input wire         i_clk,
    input wire         i_rst_n,
    input wire         s_axis_tvalid,
    input wire         s_axis_tready,
    input wire         m_axis_tvalid,
    input wire         m_axis_tready,
    input wire [143:0] m_axis_tdata
);
    `ACC_ASSERT_IMP(a_excl, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready, "ready while result pending")
    `ACC_ASSERT_NXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped")
    `ACC_ASSERT_IMP(a_nowr, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[137:136] != 2'd0, !m_axis_tdata[32] && !m_axis_tdata[65] && !m_axis_tdata[98], "write on error")
    `ACC_ASSERT_NXT(a_acc, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second accept")
endmodule
bind alu_with_condition_codes_and_branch acc_chk u_chk (.*);
`default_nettype wire
